### rtl/tqcs_pkg.sv
// Shared types and codes for the task queue scheduler.
// No dependencies; used by task_queue_concurrency_scheduler_core.
package tqcs_pkg;

   // Request codes
   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_DEQUEUE = 3'd1;
   localparam logic [2:0] OP_CANCEL  = 3'd2;
   localparam logic [2:0] OP_START   = 3'd3;
   localparam logic [2:0] OP_FINISH  = 3'd4;

   // Register indexes on the csr port
   localparam logic CSR_MODE        = 1'b0;
   localparam logic CSR_MAX_RUNNING = 1'b1;

   localparam int ENTRY_W = 48;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] instance_id;
      logic [15:0] task_ref;
   } tqcs_req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] out_instance_id;
      logic [15:0] out_task;
      logic        from_cancelled;
      logic [6:0]  cancelled_count;
      logic [6:0]  pending_count;
      logic [15:0] running_count;
      logic        locked;
   } tqcs_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_FILTER,
      ST_CREAD,
      ST_DONE
   } state_type;

endpackage

### rtl/tqcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tqcs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/task_queue_concurrency_scheduler_core.sv
// Top level of the task queue scheduler: sequencer, counters and the two stores.
// Depends on tqcs_pkg and tqcs_ram.

// One request is taken when start is high and busy is low. Busy then stays high
// until the result strobe rsp_valid, which lasts one cycle and cannot be held
// off. Enqueue, start, finish, unknown codes and a refused dequeue go from
// dispatch straight to the result. A dequeue from the cancelled FIFO reads
// that FIFO's head in a step between the two.
// A FIFO-mode dequeue and a cancel stream once over the N pending entries
// through the store's single read port and compact it in place.
// A priority-mode dequeue with more than one entry first scans for the lowest
// id and then compacts; both passes use the store's read port.
module task_queue_concurrency_scheduler_core
   import tqcs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 64,
   parameter int CANCEL_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  tqcs_req_type req_data,
   output logic         rsp_valid,
   output tqcs_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int CW  = $clog2(CANCEL_DEPTH);
   localparam int CCW = $clog2(CANCEL_DEPTH + 1);
   localparam int TW  = CW + 1;

   state_type        state_ff, state_in;
   tqcs_req_type     req_ff, req_in;
   logic [QCW-1:0]   pend_total_ff, pend_total_in;
   logic [CW-1:0]    can_head_ff, can_head_in;
   logic [CCW-1:0]   can_total_ff, can_total_in;
   logic [15:0]      run_ff, run_in;
   logic             mode_ff, mode_in;
   logic [15:0]      max_run_ff, max_run_in;
   logic [QCW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic             pv_ff, pv_in;
   logic [QW-1:0]    pidx_ff, pidx_in;
   logic [QW-1:0]    pos_ff, pos_in;
   logic [31:0]      min_id_ff, min_id_in;
   logic             ok_ff, ok_in;
   logic [31:0]      oid_ff, oid_in;
   logic [15:0]      otask_ff, otask_in;
   logic             fromc_ff, fromc_in;
   logic [QCW-1:0]   ccount_ff, ccount_in;

   logic                p_we;
   logic [QW-1:0]       p_waddr;
   logic [ENTRY_W-1:0]  p_wdata, p_rdata;
   logic                c_we;
   logic [CW-1:0]       c_waddr;
   logic [ENTRY_W-1:0]  c_rdata;

   logic                locked;
   logic [TW-1:0]       tail_sum;
   logic [CW-1:0]       tail;
   logic                issue_more, pass_done, drop;

   // Stores
   tqcs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_pending (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (rd_ptr_ff[QW-1:0]),
      .rd_data (p_rdata)
   );

   tqcs_ram #(.WIDTH(ENTRY_W), .DEPTH(CANCEL_DEPTH)) u_cancelled (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (p_rdata),
      .rd_addr (can_head_ff),
      .rd_data (c_rdata)
   );

   // Status terms
   assign locked = (can_total_ff == '0) &&
                   !((pend_total_ff != '0) && (run_ff < max_run_ff));
   assign tail_sum = TW'(can_head_ff) + TW'(can_total_ff);
   assign tail = (tail_sum >= TW'(CANCEL_DEPTH)) ?
                 CW'(tail_sum - TW'(CANCEL_DEPTH)) : CW'(tail_sum);
   assign issue_more = (rd_ptr_ff < pend_total_ff);
   assign pass_done  = !issue_more && !pv_ff;
   assign drop = (req_ff.req_type == OP_CANCEL) ?
                 ((p_rdata[47:16] == req_ff.instance_id) &&
                  (can_total_ff < CCW'(CANCEL_DEPTH))) :
                 (pidx_ff == pos_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = ST_DONE;
            if (req_ff.req_type == OP_CANCEL) begin
               state_in = ST_FILTER;
            end else if (req_ff.req_type == OP_DEQUEUE && !locked) begin
               if (can_total_ff != '0) state_in = ST_CREAD;
               else if (mode_ff && pend_total_ff > QCW'(1)) state_in = ST_SCAN;
               else state_in = ST_FILTER;
            end
         end
         ST_SCAN: begin
            if (pass_done) state_in = ST_FILTER;
         end
         ST_FILTER: begin
            if (pass_done) state_in = ST_DONE;
         end
         ST_CREAD: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      rsp_data.ok              = ok_ff;
      rsp_data.out_instance_id = oid_ff;
      rsp_data.out_task        = otask_ff;
      rsp_data.from_cancelled  = fromc_ff;
      rsp_data.cancelled_count = 7'(32'(ccount_ff));
      rsp_data.pending_count   = 7'(32'(pend_total_ff));
      rsp_data.running_count   = run_ff;
      rsp_data.locked          = locked;
   end

   // Datapath and counters
   always_comb begin
      req_in        = req_ff;
      pend_total_in = pend_total_ff;
      can_head_in   = can_head_ff;
      can_total_in  = can_total_ff;
      run_in        = run_ff;
      mode_in       = mode_ff;
      max_run_in    = max_run_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pv_in         = pv_ff;
      pidx_in       = pidx_ff;
      pos_in        = pos_ff;
      min_id_in     = min_id_ff;
      ok_in         = ok_ff;
      oid_in        = oid_ff;
      otask_in      = otask_ff;
      fromc_in      = fromc_ff;
      ccount_in     = ccount_ff;
      p_we          = 1'b0;
      p_waddr       = wr_ptr_ff[QW-1:0];
      p_wdata       = p_rdata;
      c_we          = 1'b0;
      c_waddr       = tail;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:        mode_in    = csr_wdata[0];
            CSR_MAX_RUNNING: max_run_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               ok_in     = 1'b0;
               oid_in    = '0;
               otask_in  = '0;
               fromc_in  = 1'b0;
               ccount_in = '0;
            end
         end
         ST_DISPATCH: begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            pv_in     = 1'b0;
            pos_in    = '0;
            unique case (req_ff.req_type)
               OP_ENQUEUE: begin
                  if (pend_total_ff < QCW'(QUEUE_DEPTH)) begin
                     p_we          = 1'b1;
                     p_waddr       = pend_total_ff[QW-1:0];
                     p_wdata       = {req_ff.instance_id, req_ff.task_ref};
                     pend_total_in = pend_total_ff + QCW'(1);
                     ok_in         = 1'b1;
                  end
               end
               OP_DEQUEUE: ok_in = !locked;
               OP_CANCEL:  ok_in = 1'b1;
               OP_START: begin
                  ok_in = 1'b1;
                  if (run_ff != 16'hFFFF) run_in = run_ff + 16'd1;
               end
               OP_FINISH: begin
                  ok_in = 1'b1;
                  if (run_ff != '0) run_in = run_ff - 16'd1;
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            // issue reads in order, compare each returning id to the minimum
            pv_in = issue_more;
            if (issue_more) begin
               pidx_in   = rd_ptr_ff[QW-1:0];
               rd_ptr_in = rd_ptr_ff + QCW'(1);
            end
            if (pv_ff && (pidx_ff == '0 || p_rdata[47:16] < min_id_ff)) begin
               min_id_in = p_rdata[47:16];
               pos_in    = pidx_ff;
            end
            if (pass_done) begin
               rd_ptr_in = '0;
               wr_ptr_in = '0;
            end
         end
         ST_FILTER: begin
            // stream the store, drop selected entries, compact the rest
            pv_in = issue_more;
            if (issue_more) begin
               pidx_in   = rd_ptr_ff[QW-1:0];
               rd_ptr_in = rd_ptr_ff + QCW'(1);
            end
            if (pv_ff) begin
               if (drop) begin
                  if (req_ff.req_type == OP_CANCEL) begin
                     c_we         = 1'b1;
                     can_total_in = can_total_ff + CCW'(1);
                     ccount_in    = ccount_ff + QCW'(1);
                  end else begin
                     oid_in   = p_rdata[47:16];
                     otask_in = p_rdata[15:0];
                  end
               end else begin
                  p_we      = 1'b1;
                  wr_ptr_in = wr_ptr_ff + QCW'(1);
               end
            end
            if (pass_done) pend_total_in = wr_ptr_ff;
         end
         ST_CREAD: begin
            oid_in       = c_rdata[47:16];
            otask_in     = c_rdata[15:0];
            fromc_in     = 1'b1;
            can_total_in = can_total_ff - CCW'(1);
            can_head_in  = (can_head_ff == CW'(CANCEL_DEPTH - 1)) ? '0 :
                           can_head_ff + CW'(1);
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_total_ff <= '0;
         can_head_ff   <= '0;
         can_total_ff  <= '0;
         run_ff        <= '0;
         mode_ff       <= 1'b0;
         max_run_ff    <= 16'd1;
         pv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_total_ff <= pend_total_in;
         can_head_ff   <= can_head_in;
         can_total_ff  <= can_total_in;
         run_ff        <= run_in;
         mode_ff       <= mode_in;
         max_run_ff    <= max_run_in;
         pv_ff         <= pv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      pidx_ff   <= pidx_in;
      pos_ff    <= pos_in;
      min_id_ff <= min_id_in;
      ok_ff     <= ok_in;
      oid_ff    <= oid_in;
      otask_ff  <= otask_in;
      fromc_ff  <= fromc_in;
      ccount_ff <= ccount_in;
   end

   // Checks
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_total_ff <= QCW'(QUEUE_DEPTH)) else $error("pending count overflow");
   a_can_bound: assert property (@(posedge clock) disable iff (reset)
      can_total_ff <= CCW'(CANCEL_DEPTH)) else $error("cancelled count overflow");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_fromc_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.from_cancelled) |-> rsp_data.ok)
      else $error("cancelled grant without ok");

endmodule
